// ===== rtl/kli_pkg.sv =====
// ----------------------------------------------------------------------------
// kli_pkg: shared types and constants of the keyframe interpolator
// Item layouts, keyframe store sizing and the step counts of the serial units.
// ----------------------------------------------------------------------------
package kli_pkg;

  // Keyframe table sizing.
  localparam int unsigned MAX_KEYS    = 16;
  localparam int unsigned SLOT_W      = $clog2(MAX_KEYS);
  localparam int unsigned KEY_INDEX_W = 4;
  localparam int unsigned COUNT_W     = 5;

  // Datapath widths and fixed-point format of the fraction.
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned DIVIDEND_W = DATA_W + FRAC_BITS;

  // Serial unit step counts, one bit per step.
  localparam int unsigned DIV_STEPS = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int unsigned MUL_STEPS = DATA_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS + 1);

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [KEY_INDEX_W-1:0]  key_index;
    logic signed [DATA_W-1:0] key_point;
    logic signed [DATA_W-1:0] key_value;
    logic                    key_is_last;
    logic signed [DATA_W-1:0] position;
  } cmd_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interpolated_value;
    logic                    span_fault;
  } res_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] point;
    logic signed [DATA_W-1:0] value;
  } key_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    key_entry_t        entry;
  } key_write_t;

  // Maps the slot field of an item onto a store address.
  function automatic logic [SLOT_W-1:0] slot_of(logic [KEY_INDEX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/kli_key_store.sv =====
// ----------------------------------------------------------------------------
// kli_key_store: keyframe memory
// One write port and one registered read port over point and value pairs.
// ----------------------------------------------------------------------------
module kli_key_store (
  input  logic                          clk,
  input  kli_pkg::key_write_t           wr,
  input  logic [kli_pkg::SLOT_W-1:0]    rd_addr,
  output kli_pkg::key_entry_t           rd_entry
);

  kli_pkg::key_entry_t mem [kli_pkg::MAX_KEYS];

  // Write on request; the read data is registered every cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

// ===== rtl/kli_serial_div.sv =====
// ----------------------------------------------------------------------------
// kli_serial_div: bit-serial restoring divider
// Unsigned divide, one quotient bit per cycle, keeping the low 32 quotient bits.
// ----------------------------------------------------------------------------
module kli_serial_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [kli_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [kli_pkg::DATA_W-1:0]        divisor,
  output logic                              done,
  output logic [kli_pkg::DATA_W-1:0]        quotient
);

  logic [kli_pkg::DIVIDEND_W-1:0] dvd;
  logic [kli_pkg::DATA_W-1:0]     rem;
  logic [kli_pkg::DATA_W-1:0]     dsr;
  logic [kli_pkg::DIV_CNT_W-1:0]  steps;
  logic                           busy;
  logic [kli_pkg::DATA_W:0]       shifted;
  logic [kli_pkg::DATA_W+1:0]     trial;
  logic                           fits;

  // Bring down the next dividend bit and try the subtraction.
  assign shifted = {rem, dvd[kli_pkg::DIVIDEND_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};
  assign fits    = !trial[kli_pkg::DATA_W+1];

  // Step sequencing and the shift registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      // Done pulses for one cycle after the final step.
      done <= !start && busy && (steps == kli_pkg::DIV_CNT_W'(1));
      if (start) begin
        dvd      <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        quotient <= '0;
        steps    <= kli_pkg::DIV_CNT_W'(kli_pkg::DIV_STEPS);
        busy     <= 1'b1;
      end else if (busy) begin
        dvd      <= {dvd[kli_pkg::DIVIDEND_W-2:0], 1'b0};
        rem      <= fits ? trial[kli_pkg::DATA_W-1:0] : shifted[kli_pkg::DATA_W-1:0];
        quotient <= {quotient[kli_pkg::DATA_W-2:0], fits};
        steps    <= steps - kli_pkg::DIV_CNT_W'(1);
        if (steps == kli_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/kli_serial_mul.sv =====
// ----------------------------------------------------------------------------
// kli_serial_mul: bit-serial signed multiplier
// Shift-and-add over the multiplier bits, the sign bit weighted negatively.
// ----------------------------------------------------------------------------
module kli_serial_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [kli_pkg::DATA_W-1:0]    multiplicand,
  input  logic signed [kli_pkg::DATA_W-1:0]    multiplier,
  output logic                                 done,
  output logic [2*kli_pkg::DATA_W-1:0]         product
);

  logic signed [kli_pkg::DATA_W:0]   acc_hi;
  logic [kli_pkg::DATA_W-1:0]        acc_lo;
  logic signed [kli_pkg::DATA_W-1:0] mcd;
  logic [kli_pkg::DATA_W-1:0]        mlr;
  logic [kli_pkg::MUL_CNT_W-1:0]     steps;
  logic                              busy;
  logic signed [kli_pkg::DATA_W+1:0] addend;
  logic signed [kli_pkg::DATA_W+1:0] sum;

  // Add the multiplicand for a set bit; the final bit carries negative weight.
  always_comb begin
    addend = mlr[0] ? (kli_pkg::DATA_W+2)'(mcd) : '0;
    if (steps == kli_pkg::MUL_CNT_W'(1)) begin
      sum = (kli_pkg::DATA_W+2)'(acc_hi) - addend;
    end else begin
      sum = (kli_pkg::DATA_W+2)'(acc_hi) + addend;
    end
  end

  assign product = {acc_hi[kli_pkg::DATA_W-1:0], acc_lo};

  // Accumulate and shift the partial product right by one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      // Done pulses for one cycle after the final step.
      done <= !start && busy && (steps == kli_pkg::MUL_CNT_W'(1));
      if (start) begin
        mcd    <= multiplicand;
        mlr    <= multiplier;
        acc_hi <= '0;
        acc_lo <= '0;
        steps  <= kli_pkg::MUL_CNT_W'(kli_pkg::MUL_STEPS);
        busy   <= 1'b1;
      end else if (busy) begin
        acc_hi <= sum[kli_pkg::DATA_W+1:1];
        acc_lo <= {sum[0], acc_lo[kli_pkg::DATA_W-1:1]};
        mlr    <= {1'b0, mlr[kli_pkg::DATA_W-1:1]};
        steps  <= steps - kli_pkg::MUL_CNT_W'(1);
        if (steps == kli_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/keyframe_linear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_core: piecewise linear keyframe interpolator
// Loads keyframes and samples the curve between them in 4096ths with rounding.
// ----------------------------------------------------------------------------
//   Channel  Handshake              Payload              Moves
//   command  cmd_valid / cmd_stall  cmd_item (in)        write or evaluate
//   result   res_valid / res_stall  res_item (out)       one per evaluate
//
// A write is done when taken and leaves the command channel free. The 44-step
// serial divider and 32-step serial multiplier do most of an evaluate's work.
// An empty table ends the item without a scan; a position below the first point
// or the final keyframe end it in the scan; a zero span ends it as a fault.
// Reset clears the key count and the handshake state; the store is not cleared.
// A stalled result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  kli_pkg::cmd_item_t  cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output kli_pkg::res_item_t  res_item
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DSTART,
    S_DIV,
    S_FRAC,
    S_MUL,
    S_ROUND,
    S_FIN
  } state_t;

  state_t                              state;
  logic [kli_pkg::COUNT_W-1:0]         key_count;
  logic [kli_pkg::SLOT_W-1:0]          cur;
  logic signed [kli_pkg::DATA_W-1:0]   pos;
  logic signed [kli_pkg::DATA_W-1:0]   sel_point;
  logic signed [kli_pkg::DATA_W-1:0]   sel_value;
  logic signed [kli_pkg::DATA_W-1:0]   nxt_point;
  logic signed [kli_pkg::DATA_W-1:0]   nxt_value;
  logic signed [kli_pkg::DATA_W-1:0]   span;
  logic signed [kli_pkg::DATA_W-1:0]   pdelta;
  logic signed [kli_pkg::DATA_W-1:0]   vdelta;
  logic                                q_neg;
  logic [kli_pkg::DATA_W-1:0]          result_value;
  logic                                result_fault;

  logic                                cmd_take;
  logic                                res_load;
  logic                                slot_ok;
  logic                                last_key;
  logic                                scan_above;
  kli_pkg::key_write_t                 wr;
  logic [kli_pkg::SLOT_W-1:0]          rd_addr;
  kli_pkg::key_entry_t                 rd_entry;
  logic                                div_start;
  logic                                div_done;
  logic [kli_pkg::DATA_W-1:0]          pd_mag;
  logic [kli_pkg::DATA_W-1:0]          span_mag;
  logic [kli_pkg::DATA_W-1:0]          quotient;
  logic signed [kli_pkg::DATA_W-1:0]   frac;
  logic                                mul_start;
  logic                                mul_done;
  logic [2*kli_pkg::DATA_W-1:0]        product;

  // Command side handshake: one item in flight at a time.
  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign slot_ok   = 32'(cmd_item.key_index) < kli_pkg::MAX_KEYS;

  // The result register takes a new result when it is empty or its result is leaving.
  assign res_load  = (state == S_FIN) && (!res_valid || !res_stall);

  // Keyframe write port.
  always_comb begin
    wr.en          = cmd_take && (cmd_item.command == kli_pkg::CMD_WRITE) && slot_ok;
    wr.addr        = kli_pkg::slot_of(cmd_item.key_index);
    wr.entry.point = cmd_item.key_point;
    wr.entry.value = cmd_item.key_value;
  end

  // The scan reads one slot ahead of the one being examined.
  assign rd_addr    = (state == S_SCAN) ? cur + kli_pkg::SLOT_W'(1) : '0;
  assign scan_above = rd_entry.point > pos;
  assign last_key   = (32'(cur) + 32'd1) >= 32'(key_count);

  // Operand magnitudes for the divider and the signed fraction for the multiplier.
  assign pd_mag    = pdelta[kli_pkg::DATA_W-1] ? -pdelta : pdelta;
  assign span_mag  = span[kli_pkg::DATA_W-1] ? -span : span;
  assign div_start = (state == S_DSTART) && (span != '0);
  assign frac      = q_neg ? -$signed(quotient) : $signed(quotient);
  assign mul_start = (state == S_FRAC);

  kli_key_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  kli_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({pd_mag, kli_pkg::FRAC_BITS'(0)}),
    .divisor  (span_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  kli_serial_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (vdelta),
    .multiplier   (frac),
    .done         (mul_done),
    .product      (product)
  );

  // Sequencer, datapath registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            if (cmd_item.command == kli_pkg::CMD_WRITE) begin
              if (slot_ok && cmd_item.key_is_last) begin
                key_count <= kli_pkg::COUNT_W'(cmd_item.key_index) + kli_pkg::COUNT_W'(1);
              end
            end else begin
              pos <= cmd_item.position;
              cur <= '0;
              if (key_count == '0) begin
                result_value <= '0;
                result_fault <= 1'b0;
                state        <= S_FIN;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_above) begin
            if (cur == '0) begin
              // Position lies below the first point.
              result_value <= rd_entry.value;
              result_fault <= 1'b0;
              state        <= S_FIN;
            end else begin
              nxt_point <= rd_entry.point;
              nxt_value <= rd_entry.value;
              state     <= S_PREP;
            end
          end else begin
            sel_point <= rd_entry.point;
            sel_value <= rd_entry.value;
            if (last_key) begin
              // The final keyframe holds its value.
              result_value <= rd_entry.value;
              result_fault <= 1'b0;
              state        <= S_FIN;
            end else begin
              cur <= cur + kli_pkg::SLOT_W'(1);
            end
          end
        end
        S_PREP: begin
          span   <= nxt_point - sel_point;
          pdelta <= pos - sel_point;
          vdelta <= nxt_value - sel_value;
          state  <= S_DSTART;
        end
        S_DSTART: begin
          if (span == '0) begin
            result_value <= '0;
            result_fault <= 1'b1;
            state        <= S_FIN;
          end else begin
            q_neg <= pdelta[kli_pkg::DATA_W-1] ^ span[kli_pkg::DATA_W-1];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FRAC;
          end
        end
        S_FRAC: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          // Rounding adds bit 11 of the product into the shifted sum.
          result_value <= sel_value + product[kli_pkg::DIVIDEND_W-1:kli_pkg::FRAC_BITS]
                          + kli_pkg::DATA_W'(product[kli_pkg::FRAC_BITS-1]);
          result_fault <= 1'b0;
          state        <= S_FIN;
        end
        S_FIN: begin
          if (res_load) begin
            res_item.interpolated_value <= result_value;
            res_item.span_fault         <= result_fault;
            state                       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/kli_checker.sv =====
// ----------------------------------------------------------------------------
// kli_port_checker: port-level checks of the keyframe interpolator
// Watches both channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module kli_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input kli_pkg::cmd_item_t  cmd_item,
  input logic                res_valid,
  input logic                res_stall,
  input kli_pkg::res_item_t  res_item
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed or was withdrawn");

  // A keyframe write completes in its own cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd_item.command == kli_pkg::CMD_WRITE) |=> !cmd_stall)
    else $error("command channel stalled after a keyframe write");

  // An evaluate occupies the block for the following cycle at least.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd_item.command == kli_pkg::CMD_EVAL) |=> cmd_stall)
    else $error("new transfer accepted while an evaluate was running");

  // A zero span always reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.span_fault |-> (res_item.interpolated_value == '0))
    else $error("span fault with a non-zero value");

  // Nothing is offered straight after reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

endmodule

bind keyframe_linear_interpolator_core kli_port_checker u_kli_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_item  (cmd_item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
